[design/masked_minmax_normalize_to_16bit_macros.svh]
// Assertion helpers used by the normalizer top-level RTL.
`ifndef MASKED_MINMAX_NORMALIZE_TO_16BIT_MACROS_SVH
`define MASKED_MINMAX_NORMALIZE_TO_16BIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MMN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define MMN_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[design/mmn_pkg.sv]
`timescale 1ns / 1ps

package mmn_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int ACTION_W    = 2;
  localparam int MASK_W      = 17;
  localparam int OUT_W       = 16;
  localparam int OUT_TDATA_W = 4 * OUT_W;
  localparam int CFG_INDEX_W = 3;
  localparam int AXIS_W      = 2;
  localparam int RATE_MAG_W  = 31;
  localparam int CHUNK_BITS  = 16;
  localparam int CHUNK_SEL_W = 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GATHER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EMIT   = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_X_SPAN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_X_SPAN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_SPAN_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_SPAN_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Z_SPAN_LOW  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_Z_SPAN_HIGH = 3'd5;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Thresholds and limits
  localparam logic [MASK_W-1:0] GATHER_LEVEL    = 17'd58982;
  localparam logic [MASK_W-1:0] ALPHA_LEVEL     = 17'd32768;
  localparam logic [OUT_W-1:0]  OUT_MAX         = 16'hFFFF;
  localparam logic [63:0]       SPAN_HIGH_RESET = 64'd4294967;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_MUL_START,
    ST_MUL,
    ST_ACC,
    ST_AXIS_DONE,
    ST_DELIVER
  } mmn_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                   clear;
    logic                   gather;
    logic                   load_pixel;
    logic                   div_start;
    logic                   div_step;
    logic                   div_store;
    logic                   rates_set;
    logic                   mul_start;
    logic                   mul;
    logic                   acc;
    logic                   axis_store;
    logic                   publish;
    logic [AXIS_W-1:0]      axis;
    logic [CHUNK_SEL_W-1:0] chunk;
  } mmn_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rates_ready;
    logic out_free;
  } mmn_status_t;

endpackage

[design/mmn_ctrl.sv]
`timescale 1ns / 1ps

module mmn_ctrl #(
  parameter int COORD_BITS = mmn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mmn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [mmn_pkg::ACTION_W-1:0]  in_action,
  output logic                          in_ready,
  input  mmn_pkg::mmn_status_t          status,
  output mmn_pkg::mmn_cmd_t             cmd
);
  import mmn_pkg::*;

  localparam int NB     = COORD_BITS + 1 + FRAC_BITS;
  localparam int CNT_W  = $clog2(NB);
  localparam int NCHUNK = (COORD_BITS + 1 + CHUNK_BITS - 1) / CHUNK_BITS;

  mmn_state_t             state, state_next;
  logic [AXIS_W-1:0]      axis, axis_next;
  logic [CHUNK_SEL_W-1:0] chunk, chunk_next;
  logic [CNT_W-1:0]       bit_cnt, bit_cnt_next;
  logic                   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Advance state and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      axis    <= AXIS_X;
      chunk   <= '0;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      axis    <= axis_next;
      chunk   <= chunk_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    axis_next    = axis;
    chunk_next   = chunk;
    bit_cnt_next = bit_cnt;
    case (state)
      ST_IDLE: begin
        if (accept && in_action == ACT_EMIT) begin
          axis_next  = AXIS_X;
          state_next = status.rates_ready ? ST_MUL_START : ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        bit_cnt_next = CNT_W'(NB - 1);
        state_next   = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (bit_cnt == '0) begin
          state_next = ST_DIV_DONE;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      ST_DIV_DONE: begin
        if (axis == AXIS_Z) begin
          axis_next  = AXIS_X;
          state_next = ST_MUL_START;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_DIV_START;
        end
      end
      ST_MUL_START: begin
        chunk_next = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (chunk == CHUNK_SEL_W'(NCHUNK - 1)) begin
          state_next = ST_AXIS_DONE;
        end else begin
          chunk_next = chunk + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_AXIS_DONE: begin
        if (axis == AXIS_Z) begin
          state_next = ST_DELIVER;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_MUL_START;
        end
      end
      ST_DELIVER: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd       = '0;
    cmd.axis  = axis;
    cmd.chunk = chunk;
    case (state)
      ST_IDLE: begin
        cmd.clear      = accept && in_action == ACT_CLEAR;
        cmd.gather     = accept && in_action == ACT_GATHER;
        cmd.load_pixel = accept && in_action == ACT_EMIT;
      end
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_STEP:  cmd.div_step  = 1'b1;
      ST_DIV_DONE: begin
        cmd.div_store = 1'b1;
        cmd.rates_set = (axis == AXIS_Z);
      end
      ST_MUL_START: cmd.mul_start  = 1'b1;
      ST_MUL:       cmd.mul        = 1'b1;
      ST_ACC:       cmd.acc        = 1'b1;
      ST_AXIS_DONE: cmd.axis_store = 1'b1;
      ST_DELIVER:   cmd.publish    = status.out_free;
      default: begin
        cmd.publish = 1'b0;
      end
    endcase
  end

endmodule

[design/mmn_datapath.sv]
`timescale 1ns / 1ps

module mmn_datapath #(
  parameter int COORD_BITS = mmn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mmn_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mmn_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_wdata,
  input  logic signed [COORD_BITS-1:0]         coord_x,
  input  logic signed [COORD_BITS-1:0]         coord_y,
  input  logic signed [COORD_BITS-1:0]         coord_z,
  input  logic [mmn_pkg::MASK_W-1:0]           mask,
  input  mmn_pkg::mmn_cmd_t                    cmd,
  output mmn_pkg::mmn_status_t                 status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mmn_pkg::OUT_TDATA_W-1:0]      out_data,
  output logic                                 out_fault
);
  import mmn_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int NB      = CB + 1 + FRAC_BITS;
  localparam int QW      = (NB > 32) ? NB : 32;
  localparam int NCHUNK  = (CB + 1 + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int DW      = NCHUNK * CHUNK_BITS;
  localparam int PROD_W  = CHUNK_BITS + RATE_MAG_W;
  localparam int ACC_RAW = DW + RATE_MAG_W;
  localparam int ACC_W   = (ACC_RAW > 2 * FRAC_BITS + OUT_W) ? ACC_RAW
                                                            : 2 * FRAC_BITS + OUT_W + 1;
  localparam int SH      = 2 * FRAC_BITS;
  localparam logic [CB-1:0] MOST_POS = {1'b0, {(CB - 1){1'b1}}};
  localparam logic [CB-1:0] MOST_NEG = {1'b1, {(CB - 1){1'b0}}};

  // Configuration and statistics
  logic signed [CB-1:0] span_lo [3];
  logic signed [CB-1:0] span_hi [3];
  logic signed [CB-1:0] low_v   [3];
  logic signed [CB-1:0] high_v  [3];
  logic                 rates_ready;

  // Latched emit pixel
  logic signed [CB-1:0] pix [3];
  logic [MASK_W-1:0]    pix_mask;

  // Divider
  logic [NB-1:0] dvd;
  logic [CB:0]   rem;
  logic [CB:0]   den;
  logic [QW-1:0] quo;

  // Rates as sign and magnitude
  logic [RATE_MAG_W-1:0] rate_mag [3];
  logic                  rate_neg [3];

  // Multiplier
  logic [DW-1:0]     dmag;
  logic              prod_neg;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;

  // Results
  logic [OUT_W-1:0] res_val [3];
  logic             res_fault;

  // Axis-selected values
  logic signed [CB-1:0] sel_lo, sel_hi, sel_low, sel_high, sel_pix;
  logic [CB:0]          num, num_mag, span_obs, diff, diff_mag, trial;
  logic                 sel_empty, fold;
  logic                 big, mzero;
  logic [OUT_W-1:0]     axis_val;
  logic                 axis_fault;

  assign sel_lo    = span_lo[cmd.axis];
  assign sel_hi    = span_hi[cmd.axis];
  assign sel_low   = low_v[cmd.axis];
  assign sel_high  = high_v[cmd.axis];
  assign sel_pix   = pix[cmd.axis];
  assign sel_empty = !(sel_high > sel_low);

  assign num      = {sel_hi[CB-1], sel_hi} - {sel_lo[CB-1], sel_lo};
  assign num_mag  = num[CB] ? (~num + {{CB{1'b0}}, 1'b1}) : num;
  assign span_obs = {sel_high[CB-1], sel_high} - {sel_low[CB-1], sel_low};
  assign diff     = {sel_pix[CB-1], sel_pix} - {sel_low[CB-1], sel_low};
  assign diff_mag = diff[CB] ? (~diff + {{CB{1'b0}}, 1'b1}) : diff;
  assign trial    = {rem[CB-1:0], dvd[NB-1]};
  assign fold     = mask > GATHER_LEVEL;

  // Saturate the scaled product of the current axis
  assign big   = |acc[ACC_W-1:SH+OUT_W];
  assign mzero = (acc[ACC_W-1:SH] == '0);
  always_comb begin
    axis_val   = acc[SH+OUT_W-1:SH];
    axis_fault = 1'b0;
    if (sel_empty) begin
      axis_val   = '0;
      axis_fault = 1'b1;
    end else if (mzero) begin
      axis_val = '0;
    end else if (prod_neg) begin
      axis_val   = '0;
      axis_fault = 1'b1;
    end else if (big) begin
      axis_val   = OUT_MAX;
      axis_fault = 1'b1;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      span_lo[0] <= '0;
      span_lo[1] <= '0;
      span_lo[2] <= '0;
      span_hi[0] <= SPAN_HIGH_RESET[CB-1:0];
      span_hi[1] <= SPAN_HIGH_RESET[CB-1:0];
      span_hi[2] <= SPAN_HIGH_RESET[CB-1:0];
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_X_SPAN_LOW:  span_lo[0] <= cfg_wdata;
        REG_X_SPAN_HIGH: span_hi[0] <= cfg_wdata;
        REG_Y_SPAN_LOW:  span_lo[1] <= cfg_wdata;
        REG_Y_SPAN_HIGH: span_hi[1] <= cfg_wdata;
        REG_Z_SPAN_LOW:  span_lo[2] <= cfg_wdata;
        REG_Z_SPAN_HIGH: span_hi[2] <= cfg_wdata;
        default: begin
          span_lo[0] <= span_lo[0];
        end
      endcase
    end
  end

  // Clear or fold the running bounds
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 3; i++) begin
        low_v[i]  <= MOST_POS;
        high_v[i] <= MOST_NEG;
      end
      rates_ready <= 1'b0;
    end else if (cmd.gather) begin
      if (fold) begin
        if (coord_x < low_v[0])  low_v[0]  <= coord_x;
        if (coord_x > high_v[0]) high_v[0] <= coord_x;
        if (coord_y < low_v[1])  low_v[1]  <= coord_y;
        if (coord_y > high_v[1]) high_v[1] <= coord_y;
        if (coord_z < low_v[2])  low_v[2]  <= coord_z;
        if (coord_z > high_v[2]) high_v[2] <= coord_z;
      end
      rates_ready <= 1'b0;
    end else if (cmd.rates_set) begin
      rates_ready <= 1'b1;
    end
  end

  // Hold the emit pixel
  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      pix[0]   <= coord_x;
      pix[1]   <= coord_y;
      pix[2]   <= coord_z;
      pix_mask <= mask;
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= {num_mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      den <= span_obs;
      quo <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[NB-2:0], 1'b0};
      if (trial >= den) begin
        rem <= trial - den;
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  // Store the clamped rate of the current axis
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (sel_empty) begin
        rate_mag[cmd.axis] <= '0;
        rate_neg[cmd.axis] <= 1'b0;
      end else begin
        rate_mag[cmd.axis] <= (|quo[QW-1:RATE_MAG_W]) ? {RATE_MAG_W{1'b1}}
                                                      : quo[RATE_MAG_W-1:0];
        rate_neg[cmd.axis] <= num[CB];
      end
    end
  end

  // Multiply offset magnitude by rate, one chunk per pass
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      dmag     <= DW'(diff_mag);
      prod_neg <= diff[CB] ^ rate_neg[cmd.axis];
      acc      <= '0;
    end else if (cmd.mul) begin
      prod <= rate_mag[cmd.axis] * dmag[cmd.chunk * CHUNK_BITS +: CHUNK_BITS];
    end else if (cmd.acc) begin
      acc <= acc + (ACC_W'(prod) << (cmd.chunk * CHUNK_BITS));
    end
  end

  // Collect per-axis results
  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      res_fault <= 1'b0;
    end else if (cmd.axis_store) begin
      res_val[cmd.axis] <= axis_val;
      res_fault         <= res_fault | axis_fault;
    end
  end

  // Output register: load on publish, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data  <= {(pix_mask > ALPHA_LEVEL) ? OUT_MAX : {OUT_W{1'b0}},
                    res_val[2], res_val[1], res_val[0]};
      out_fault <= res_fault;
    end
  end

  assign status.rates_ready = rates_ready;
  assign status.out_free    = !out_valid || out_ready;

endmodule

[design/masked_minmax_normalize_to_16bit.sv]
`timescale 1ns / 1ps

// Masked min-max normalizer: clear (action 0) and gather (action 1) act on
// acceptance and may follow each other back to back; a gathered pixel folds
// into the per-axis bounds when its mask is above 0.9. An emit (action 2)
// yields one result, (v - min) * rate per axis saturated to 16 bits, plus
// alpha and a fault flag, computed on the shared 31x16 multiplier that
// walks each axis offset in NCHUNK = ceil((COORD_BITS + 1) / 16) chunks
// of 16 bits. The first emit after reset, clear or gather also works out
// the three rates on a restoring divider that retires one quotient bit per
// cycle. Inputs are not taken while an emit is in progress; a finished
// result waits in the output register while the next item is taken.
module masked_minmax_normalize_to_16bit #(
  parameter int COORD_BITS = mmn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mmn_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [mmn_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_wdata,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coord_x, coord_y, coord_z, mask, zero fill
  input  logic [((3*COORD_BITS+mmn_pkg::MASK_W+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [mmn_pkg::ACTION_W-1:0]        s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_x, out_y, out_z, out_alpha
  output logic [mmn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // range_fault
  output logic [0:0]                          m_axis_tuser
);
  import mmn_pkg::*;

  localparam int CB = COORD_BITS;

  mmn_cmd_t             cmd;
  mmn_status_t          status;
  logic signed [CB-1:0] coord_x, coord_y, coord_z;
  logic [MASK_W-1:0]    mask;
  logic                 out_fault;

  // Unpack the input transfer
  assign coord_x = s_axis_tdata[CB-1:0];
  assign coord_y = s_axis_tdata[2*CB-1:CB];
  assign coord_z = s_axis_tdata[3*CB-1:2*CB];
  assign mask    = s_axis_tdata[3*CB+MASK_W-1:3*CB];

  mmn_ctrl #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_action(s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mmn_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .coord_z  (coord_z),
    .mask     (mask),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_fault(out_fault)
  );

  assign m_axis_tuser = out_fault;

  `include "masked_minmax_normalize_to_16bit_macros.svh"

  // An emit transfer keeps the input closed on the next cycle
  `MMN_ASSERT_NEXT(a_emit_blocks_input, s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_EMIT, !s_axis_tready, "input open right after emit")
  // A result is never loaded over one still waiting
  `MMN_ASSERT(a_no_overwrite, !(cmd.publish && m_axis_tvalid && !m_axis_tready), "pending result overwritten")
  // A result appears only after the controller publishes it
  `MMN_ASSERT(a_valid_from_publish, ($rose(m_axis_tvalid) |-> $past(cmd.publish)), "result valid without publish")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mmn_pkg::*;

  localparam int CW         = COORD_BITS_DEF;
  localparam int FB         = FRAC_BITS_DEF;
  localparam int IN_TDATA_W = ((3 * CW + MASK_W + 7) / 8) * 8;
  localparam int FILL_W     = IN_TDATA_W - 3 * CW - MASK_W;
  localparam int PHASE_ITEMS = 330;

  // Action 3 is not decoded by the block
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [CW-1:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [CW-1:0] ONE_Q    = 32'h0001_0000;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic [OUT_W-1:0] alpha;
    logic             fault;
  } norm_px_t;

  // Tracks bounds, rates and span registers; queues the normalized pixels to come
  class pixel_norm_model;
    logic signed [CW-1:0] span_reg [6];
    logic signed [CW-1:0] lo_b [3];
    logic signed [CW-1:0] hi_b [3];
    logic signed [31:0]   rate [3];
    bit                   rates_valid;
    norm_px_t             want_px [$];
    int unsigned          n_bad;

    function new();
      span_reg[REG_X_SPAN_LOW]  = '0;
      span_reg[REG_X_SPAN_HIGH] = SPAN_HIGH_RESET[CW-1:0];
      span_reg[REG_Y_SPAN_LOW]  = '0;
      span_reg[REG_Y_SPAN_HIGH] = SPAN_HIGH_RESET[CW-1:0];
      span_reg[REG_Z_SPAN_LOW]  = '0;
      span_reg[REG_Z_SPAN_HIGH] = SPAN_HIGH_RESET[CW-1:0];
      n_bad = 0;
      clear_bounds();
    endfunction

    function void report(string msg);
      if (n_bad < 50) $display("mismatch at %0t: %s", $realtime, msg);
      n_bad++;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] val);
      span_reg[idx] = val;
    endfunction

    function void clear_bounds();
      for (int a = 0; a < 3; a++) begin
        lo_b[a] = MOST_POS;
        hi_b[a] = MOST_NEG;
        rate[a] = '0;
      end
      rates_valid = 1'b0;
    endfunction

    // Target span over observed span, truncated to FB fraction bits, magnitude clamped
    function logic signed [31:0] axis_rate(int a);
      longint          num;
      longint unsigned den, un, mag;
      if (hi_b[a] <= lo_b[a]) return '0;
      num = longint'(span_reg[2*a+1]) - longint'(span_reg[2*a]);
      den = longint'(hi_b[a]) - longint'(lo_b[a]);
      un  = (num < 0) ? -num : num;
      mag = (un << FB) / den;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return (num < 0) ? -mag[31:0] : mag[31:0];
    endfunction

    // Offset from the minimum times the rate, truncated, clamped to 16 bits
    function logic [OUT_W-1:0] axis_value(int a, logic signed [CW-1:0] v, inout bit fault);
      longint          d;
      longint unsigned ad, ar, prod;
      bit              neg;
      if (hi_b[a] <= lo_b[a]) begin
        fault = 1'b1;
        return '0;
      end
      d    = longint'(v) - longint'(lo_b[a]);
      neg  = (d < 0) != (rate[a] < 0);
      ad   = (d < 0) ? -d : d;
      ar   = (rate[a] < 0) ? -longint'(rate[a]) : longint'(rate[a]);
      prod = (ad * ar) >> (2 * FB);
      if (prod == 0) return '0;
      if (neg) begin
        fault = 1'b1;
        return '0;
      end
      if (prod > OUT_MAX) begin
        fault = 1'b1;
        return OUT_MAX;
      end
      return prod[OUT_W-1:0];
    endfunction

    // Apply one accepted input transfer
    function void take_pixel(logic [ACTION_W-1:0] act, logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                             logic [MASK_W-1:0] m);
      logic signed [CW-1:0] v [3];
      norm_px_t px;
      bit fault;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      case (act)
        ACT_CLEAR: begin
          clear_bounds();
        end
        ACT_GATHER: begin
          if (m > GATHER_LEVEL) begin
            for (int a = 0; a < 3; a++) begin
              if (v[a] < lo_b[a]) lo_b[a] = v[a];
              if (v[a] > hi_b[a]) hi_b[a] = v[a];
            end
          end
          rates_valid = 1'b0;
        end
        ACT_EMIT: begin
          if (!rates_valid) begin
            for (int a = 0; a < 3; a++) rate[a] = axis_rate(a);
            rates_valid = 1'b1;
          end
          fault    = 1'b0;
          px.x     = axis_value(0, v[0], fault);
          px.y     = axis_value(1, v[1], fault);
          px.z     = axis_value(2, v[2], fault);
          px.alpha = (m > ALPHA_LEVEL) ? OUT_MAX : '0;
          px.fault = fault;
          want_px.push_back(px);
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one accepted result transfer with the oldest pending pixel
    function void check_pixel(logic [OUT_TDATA_W-1:0] data, logic fault);
      norm_px_t want;
      if (want_px.size() == 0) begin
        report("result with no pixel pending");
        return;
      end
      want = want_px.pop_front();
      if (data[15:0] !== want.x)
        report($sformatf("out_x got %0d want %0d", data[15:0], want.x));
      if (data[31:16] !== want.y)
        report($sformatf("out_y got %0d want %0d", data[31:16], want.y));
      if (data[47:32] !== want.z)
        report($sformatf("out_z got %0d want %0d", data[47:32], want.z));
      if (data[63:48] !== want.alpha)
        report($sformatf("out_alpha got %0d want %0d", data[63:48], want.alpha));
      if (fault !== want.fault)
        report($sformatf("range_fault got %0b want %0b", fault, want.fault));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CW-1:0]          cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  int unsigned src_idle_pct = 24;
  int unsigned dst_idle_pct = 76;
  int unsigned n_sent = 0;

  pixel_norm_model pred = new();

  masked_minmax_normalize_to_16bit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Watch both streams; feed the model and check results
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        pred.check_pixel(m_axis_tdata, m_axis_tuser[0]);
      if (s_axis_tvalid && s_axis_tready)
        pred.take_pixel(s_axis_tuser, s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                        s_axis_tdata[3*CW-1:2*CW], s_axis_tdata[3*CW+MASK_W-1:3*CW]);
    end
  end

  task automatic send_px(input logic [ACTION_W-1:0] act, input logic [CW-1:0] x,
                         input logic [CW-1:0] y, input logic [CW-1:0] z,
                         input logic [MASK_W-1:0] m);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {{FILL_W{1'b0}}, m, z, y, x};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (act != ACT_UNUSED) n_sent++;
  endtask

  // Hold the input side until every pending pixel has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pred.want_px.size() != 0) @(posedge clk);
  endtask

  // Drain, then let a trailing clear or gather finish before touching registers
  task automatic settle();
    drain();
    repeat (200) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    pred.set_reg(idx, val);
  endtask

  task automatic write_spans(input logic [CW-1:0] xl, input logic [CW-1:0] xh,
                             input logic [CW-1:0] yl, input logic [CW-1:0] yh,
                             input logic [CW-1:0] zl, input logic [CW-1:0] zh);
    put_reg(REG_X_SPAN_LOW, xl);
    put_reg(REG_X_SPAN_HIGH, xh);
    put_reg(REG_Y_SPAN_LOW, yl);
    put_reg(REG_Y_SPAN_HIGH, yh);
    put_reg(REG_Z_SPAN_LOW, zl);
    put_reg(REG_Z_SPAN_HIGH, zh);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CW-1:0] pick_span();
    case ($urandom_range(4))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  // Random value near a center; width 32 gives a fully random value
  function automatic logic [CW-1:0] near(input logic [CW-1:0] c, input int unsigned w);
    logic [CW-1:0] r;
    r = $urandom;
    if (w >= 32) return r;
    return c + (r >> (32 - w));
  endfunction

  function automatic logic [MASK_W-1:0] fold_mask();
    if ($urandom_range(4) == 0) return MASK_W'($urandom_range(0, 131071));
    return MASK_W'($urandom_range(58983, 65536));
  endfunction

  function automatic logic [MASK_W-1:0] any_mask();
    if ($urandom_range(7) == 0) return MASK_W'($urandom_range(0, 131071));
    return MASK_W'($urandom_range(0, 65536));
  endfunction

  // One frame: a burst of random actions, or optional clear, a few gathers around a center, then emits
  task automatic run_frame();
    logic [CW-1:0] cx, cy, cz;
    int unsigned   w;
    if ($urandom_range(49) == 0) drain();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_px(ACTION_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                MASK_W'($urandom_range(0, 131071)));
      return;
    end
    if ($urandom_range(3) != 0) send_px(ACT_CLEAR, $urandom, $urandom, $urandom, any_mask());
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    w  = $urandom_range(0, 32);
    repeat ($urandom_range(1, 8))
      send_px(ACT_GATHER, near(cx, w), near(cy, w), near(cz, w), fold_mask());
    repeat ($urandom_range(1, 6))
      send_px(ACT_EMIT, near(cx, w), near(cy, w), near(cz, w), any_mask());
  endtask

  task automatic run_phase();
    int unsigned start;
    start = n_sent;
    while (n_sent - start < PHASE_ITEMS) run_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No masked pixel yet: every axis faults
    send_px(ACT_EMIT, '0, '0, '0, 17'd65536);
    // Fold the extremes; a mask at exactly 0.9 must not fold
    send_px(ACT_GATHER, MOST_NEG, MOST_NEG, MOST_NEG, 17'd58983);
    send_px(ACT_GATHER, MOST_POS, MOST_POS, MOST_POS, 17'd131071);
    send_px(ACT_GATHER, 32'h1234_0000, '0, 32'hFFFF_0000, 17'd58982);
    send_px(ACT_EMIT, MOST_NEG, MOST_NEG, MOST_NEG, 17'd32768);
    send_px(ACT_EMIT, MOST_POS, MOST_POS, MOST_POS, 17'd32769);
    send_px(ACT_EMIT, '0, '0, '0, 17'd131071);
    send_px(ACT_UNUSED, MOST_POS, MOST_NEG, '1, 17'd65536);
    // Single pixel gives zero span
    send_px(ACT_CLEAR, '1, '1, '1, 17'd131071);
    send_px(ACT_GATHER, 5 * ONE_Q, -3 * ONE_Q, 32'd100, 17'd65536);
    send_px(ACT_EMIT, 5 * ONE_Q, -3 * ONE_Q, 32'd100, 17'd65536);
    // Small spans: in range, below the minimum, saturated
    send_px(ACT_GATHER, 7 * ONE_Q, ONE_Q, 32'd200, 17'd65536);
    send_px(ACT_EMIT, 6 * ONE_Q, '0, 32'd150, '0);
    send_px(ACT_EMIT, '0, -4 * ONE_Q, 32'd99, '0);
    send_px(ACT_EMIT, MOST_POS, MOST_POS, MOST_POS, '0);
    send_px(ACT_EMIT, 5 * ONE_Q + 1, -3 * ONE_Q + 1, 32'd101, 17'd40000);

    // Register writes while rates are held take effect only after a gather
    settle();
    write_spans(MOST_POS, MOST_NEG, MOST_NEG, MOST_POS, 5 * ONE_Q, 5 * ONE_Q);
    send_px(ACT_EMIT, 6 * ONE_Q, '0, 32'd150, 17'd65536);
    send_px(ACT_GATHER, MOST_POS, MOST_POS, MOST_POS, '0);
    send_px(ACT_EMIT, 6 * ONE_Q, '0, 32'd150, 17'd65536);
    send_px(ACT_EMIT, 5 * ONE_Q, 7 * ONE_Q, 32'd200, 17'd65536);

    // Sender mostly busy, receiver mostly stalled; full-width x target span
    settle();
    write_spans(MOST_NEG, MOST_POS, '0, MOST_POS, pick_span(), pick_span());
    run_phase();

    // Sender mostly idle, receiver mostly ready
    settle();
    src_idle_pct = 76;
    dst_idle_pct = 24;
    write_spans(pick_span(), pick_span(), pick_span(), pick_span(), pick_span(), pick_span());
    run_phase();

    // No idling on either side; default x span, negative y span, zero z span
    settle();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_spans('0, SPAN_HIGH_RESET[CW-1:0], MOST_POS, MOST_NEG, ONE_Q, ONE_Q);
    run_phase();

    drain();
    repeat (300) @(posedge clk);
    if (pred.n_bad == 0 && pred.want_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/mmn_pkg.sv
design/mmn_ctrl.sv
design/mmn_datapath.sv
design/masked_minmax_normalize_to_16bit.sv
sim/testbench.sv
